// ===== hdl/dmse_pkg.sv =====
// ----------------------------------------------------------------------------
// dmse_pkg
// Shared codes and controller/datapath command and status types for the
// degree matrix swap engine.
// ----------------------------------------------------------------------------
package dmse_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SWAP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_LIGHT     = 2'd2;
    localparam logic [1:0] ST_NO_CAP    = 2'd3;

    // pair entry selects: (row,col) taken from the item indices
    localparam logic [2:0] P_RACA = 3'd0;
    localparam logic [2:0] P_CARA = 3'd1;
    localparam logic [2:0] P_RBCB = 3'd2;
    localparam logic [2:0] P_CBRB = 3'd3;
    localparam logic [2:0] P_RACB = 3'd4;
    localparam logic [2:0] P_CBRA = 3'd5;
    localparam logic [2:0] P_RBCA = 3'd6;
    localparam logic [2:0] P_CARB = 3'd7;

    // single index selects
    localparam logic [1:0] X_RA = 2'd0;
    localparam logic [1:0] X_CA = 2'd1;
    localparam logic [1:0] X_RB = 2'd2;
    localparam logic [1:0] X_CB = 2'd3;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_RD   = 2'd1;
    localparam logic [1:0] RES_K    = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       clr;
        logic       p_rd;
        logic       p_we;
        logic [2:0] p_sel;
        logic       r_rd;
        logic [1:0] r_sel;
        logic       r_we;
        logic       r_wsel;
        logic       div_go;
        logic       div_mod;
        logic [1:0] div_q;
        logic       mul_go;
        logic       mul_sel;
        logic       lim_init;
        logic       lim_upd;
        logic       emit;
        logic [1:0] emit_st;
        logic [1:0] emit_res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       rw_bad;
        logic       sw_bad;
        logic       diag;
        logic       light;
        logic       clr_last;
        logic       div_done;
        logic       mul_done;
        logic       cap_fail;
        logic       ovf;
    } t_sts;

endpackage

// ===== hdl/dmse_div.sv =====
// ----------------------------------------------------------------------------
// dmse_div
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module dmse_div #(
    parameter int DW = 38
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic [DW-1:0] o_quot,
    output logic [31:0]   o_rem,
    output logic          o_done
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_div;
    logic [32:0]   w_t;
    logic          w_ge;

    assign w_t  = {r_rem, r_q[DW-1]};
    assign w_ge = w_t >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= 32'(w_t - {1'b0, r_div});
            end else begin
                r_rem <= w_t[31:0];
            end
            r_q <= {r_q[DW-2:0], w_ge};
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== hdl/dmse_mul.sv =====
// ----------------------------------------------------------------------------
// dmse_mul
// Shift-add multiplier, one bit per cycle, result held at 2**33 once reached.
// ----------------------------------------------------------------------------
module dmse_mul #(
    parameter int NW = 38
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_a,
    input  logic [NW-1:0] i_b,
    output logic [33:0]   o_prod,
    output logic          o_done
);
    localparam logic [33:0] SAT = 34'h2_0000_0000;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [33:0] r_acc;
    logic [33:0] r_a;
    logic [33:0] r_b;
    logic [33:0] w_ca;
    logic [33:0] w_cb;
    logic [35:0] w_t;

    assign w_ca = (|(i_a >> 33)) ? SAT : 34'(i_a);
    assign w_cb = (|(i_b >> 33)) ? SAT : 34'(i_b);
    assign w_t  = {1'b0, r_acc, 1'b0} + {2'b00, (r_b[33] ? r_a : 34'd0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= w_ca;
            r_b   <= w_cb;
        end else if (r_busy) begin
            r_acc <= (w_t >= 36'(SAT)) ? SAT : w_t[33:0];
            r_b   <= {r_b[32:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== hdl/dmse_dpath.sv =====
// ----------------------------------------------------------------------------
// dmse_dpath
// Pair count and row total memories, operand registers, shared divider,
// capacity multiplier and result register.
// ----------------------------------------------------------------------------
module dmse_dpath #(
    parameter int DEGREE_SLOTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmse_pkg::t_cmd i_cmd,
    output dmse_pkg::t_sts o_sts,
    input  logic [1:0]     i_opcode,
    input  logic [5:0]     i_row_a,
    input  logic [5:0]     i_col_a,
    input  logic [5:0]     i_row_b,
    input  logic [5:0]     i_col_b,
    input  logic [31:0]    i_count_value,
    input  logic [30:0]    i_random_draw,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [31:0]    o_result_value
);
    import dmse_pkg::*;

    localparam int IW = $clog2(DEGREE_SLOTS);
    localparam int RW = 32 + IW;
    localparam int AW = 2 * IW;
    localparam int PD = 1 << AW;
    localparam int RD = 1 << IW;

    logic [1:0]    r_op;
    logic [5:0]    r_ra, r_ca, r_rb, r_cb;
    logic [31:0]   r_cnt;
    logic [30:0]   r_draw;
    logic [31:0]   r_x1, r_x2, r_c12, r_c21;
    logic [RW-1:0] r_tot;
    logic [RW-1:0] r_n_ra, r_n_ca, r_n_rb, r_n_cb;
    logic [31:0]   r_lim;
    logic [31:0]   r_k;
    logic [AW-1:0] r_clr_cnt;
    logic          r_p_cap;
    logic [2:0]    r_p_csel;
    logic          r_r_cap;
    logic          r_div_mod;
    logic [1:0]    r_div_q;
    logic          r_mul_sel;
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_result;
    logic [31:0]   r_p_rd;
    logic [RW-1:0] r_r_rd;

    logic [31:0]   m_pair [PD];
    logic [RW-1:0] m_row  [RD];

    logic [AW-1:0] w_p_addr;
    logic [AW-1:0] w_p_wa;
    logic [31:0]   w_p_wd;
    logic          w_p_we;
    logic [IW-1:0] w_r_ra;
    logic [IW-1:0] w_r_wa;
    logic [RW-1:0] w_r_wd;
    logic          w_r_we;
    logic [5:0]    w_div_idx;
    logic [RW-1:0] w_dvd;
    logic [31:0]   w_dvs;
    logic [RW-1:0] w_quot;
    logic [31:0]   w_rem;
    logic          w_div_done;
    logic [RW-1:0] w_ma, w_mb;
    logic [33:0]   w_prod;
    logic          w_mul_done;
    logic [33:0]   w_mc;
    logic [33:0]   w_avail;
    logic [32:0]   w_s1, w_s2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_ra   <= i_row_a;
            r_ca   <= i_col_a;
            r_rb   <= i_row_b;
            r_cb   <= i_col_b;
            r_cnt  <= i_count_value;
            r_draw <= i_random_draw;
        end
    end

    always_comb begin
        case (i_cmd.p_sel)
            P_RACA:  w_p_addr = {IW'(r_ra), IW'(r_ca)};
            P_CARA:  w_p_addr = {IW'(r_ca), IW'(r_ra)};
            P_RBCB:  w_p_addr = {IW'(r_rb), IW'(r_cb)};
            P_CBRB:  w_p_addr = {IW'(r_cb), IW'(r_rb)};
            P_RACB:  w_p_addr = {IW'(r_ra), IW'(r_cb)};
            P_CBRA:  w_p_addr = {IW'(r_cb), IW'(r_ra)};
            P_RBCA:  w_p_addr = {IW'(r_rb), IW'(r_ca)};
            default: w_p_addr = {IW'(r_ca), IW'(r_rb)};
        endcase
        case (i_cmd.p_sel)
            P_RACA, P_CARA: w_p_wd = (r_op == OP_LOAD) ? r_cnt : r_x1 - r_k;
            P_RBCB, P_CBRB: w_p_wd = r_x2 - r_k;
            P_RACB, P_CBRA: w_p_wd = r_c12 + r_k;
            default:        w_p_wd = r_c21 + r_k;
        endcase
        case (i_cmd.r_sel)
            X_RA:    w_r_ra = IW'(r_ra);
            X_CA:    w_r_ra = IW'(r_ca);
            X_RB:    w_r_ra = IW'(r_rb);
            default: w_r_ra = IW'(r_cb);
        endcase
        case (i_cmd.div_q)
            X_RA:    w_div_idx = r_ra;
            X_CA:    w_div_idx = r_ca;
            X_RB:    w_div_idx = r_rb;
            default: w_div_idx = r_cb;
        endcase
    end

    assign w_p_we = i_cmd.clr || i_cmd.p_we;
    assign w_p_wa = i_cmd.clr ? r_clr_cnt : w_p_addr;
    assign w_r_we = i_cmd.clr || i_cmd.r_we;
    assign w_r_wa = i_cmd.clr ? r_clr_cnt[IW-1:0] : (i_cmd.r_wsel ? IW'(r_ca) : IW'(r_ra));
    assign w_r_wd = i_cmd.clr ? '0 : r_tot - RW'(r_x1) + RW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            m_pair[w_p_wa] <= i_cmd.clr ? 32'd0 : w_p_wd;
        end
        if (i_cmd.p_rd) begin
            r_p_rd <= m_pair[w_p_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r_we) begin
            m_row[w_r_wa] <= w_r_wd;
        end
        if (i_cmd.r_rd) begin
            r_r_rd <= m_row[w_r_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_p_cap   <= 1'b0;
            r_r_cap   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            r_p_cap   <= i_cmd.p_rd;
            r_r_cap   <= i_cmd.r_rd;
            r_o_valid <= i_cmd.emit;
        end
    end

    assign w_dvd = i_cmd.div_mod ? RW'(r_draw) : r_r_rd;
    assign w_dvs = i_cmd.div_mod ? r_lim : 32'(w_div_idx);

    dmse_div #(.DW(RW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_done     (w_div_done)
    );

    assign w_ma = i_cmd.mul_sel ? r_n_rb : r_n_ra;
    assign w_mb = i_cmd.mul_sel ? r_n_ca : r_n_cb;

    dmse_mul #(.NW(RW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_prod  (w_prod),
        .o_done  (w_mul_done)
    );

    assign w_mc    = 34'(r_mul_sel ? r_c21 : r_c12);
    assign w_avail = w_prod - w_mc;
    assign w_s1    = 33'(r_c12) + 33'(r_k);
    assign w_s2    = 33'(r_c21) + 33'(r_k);

    always_ff @(posedge i_clk) begin
        if (r_p_cap) begin
            case (r_p_csel)
                P_RACA:  r_x1  <= r_p_rd;
                P_RBCB:  r_x2  <= r_p_rd;
                P_RACB:  r_c12 <= r_p_rd;
                P_RBCA:  r_c21 <= r_p_rd;
                default: r_x1  <= r_x1;
            endcase
        end
        r_p_csel <= i_cmd.p_sel;
        if (r_r_cap) begin
            r_tot <= r_r_rd;
        end
        if (i_cmd.div_go) begin
            r_div_mod <= i_cmd.div_mod;
            r_div_q   <= i_cmd.div_q;
        end
        if (w_div_done) begin
            if (r_div_mod) begin
                r_k <= w_rem + 32'd1;
            end else begin
                case (r_div_q)
                    X_RA:    r_n_ra <= w_quot;
                    X_CA:    r_n_ca <= w_quot;
                    X_RB:    r_n_rb <= w_quot;
                    default: r_n_cb <= w_quot;
                endcase
            end
        end
        if (i_cmd.mul_go) begin
            r_mul_sel <= i_cmd.mul_sel;
        end
        if (i_cmd.lim_init) begin
            r_lim <= (r_x1 < r_x2) ? r_x1 : r_x2;
        end else if (i_cmd.lim_upd && (w_avail < 34'(r_lim))) begin
            r_lim <= w_avail[31:0];
        end
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.emit_st;
            case (i_cmd.emit_res)
                RES_RD:  r_o_result <= r_x1;
                RES_K:   r_o_result <= r_k;
                default: r_o_result <= 32'd0;
            endcase
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.rw_bad   = (32'(r_ra) >= 32'(DEGREE_SLOTS)) || (32'(r_ca) >= 32'(DEGREE_SLOTS));
    assign o_sts.sw_bad   = (r_ra == 6'd0) || (r_ca == 6'd0) || (r_rb == 6'd0) || (r_cb == 6'd0)
                         || (r_ra >= r_ca) || (r_rb >= r_cb)
                         || (32'(r_ca) >= 32'(DEGREE_SLOTS)) || (32'(r_cb) >= 32'(DEGREE_SLOTS))
                         || (r_rb == r_ra) || (r_rb == r_ca) || (r_cb == r_ra) || (r_cb == r_ca);
    assign o_sts.diag     = (r_ra == r_ca);
    assign o_sts.light    = (r_x1 < 32'd2) || (r_x2 < 32'd2);
    assign o_sts.clr_last = &r_clr_cnt;
    assign o_sts.div_done = w_div_done;
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.cap_fail = w_prod <= w_mc;
    assign o_sts.ovf      = w_s1[32] || w_s2[32];

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_value = r_o_result;

endmodule

// ===== hdl/dmse_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmse_ctrl
// Sequencer: clearing pass, load, read and swap attempt command sequences.
// ----------------------------------------------------------------------------
module dmse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dmse_pkg::t_sts i_sts,
    output dmse_pkg::t_cmd o_cmd
);
    import dmse_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DEC  = 5'd2;
    localparam logic [4:0] S_RD1  = 5'd3;
    localparam logic [4:0] S_RD2  = 5'd4;
    localparam logic [4:0] S_L1   = 5'd5;
    localparam logic [4:0] S_L2   = 5'd6;
    localparam logic [4:0] S_L3   = 5'd7;
    localparam logic [4:0] S_L4   = 5'd8;
    localparam logic [4:0] S_L5   = 5'd9;
    localparam logic [4:0] S_SA   = 5'd10;
    localparam logic [4:0] S_SB   = 5'd11;
    localparam logic [4:0] S_SC   = 5'd12;
    localparam logic [4:0] S_SD   = 5'd13;
    localparam logic [4:0] S_DVR  = 5'd14;
    localparam logic [4:0] S_DVG  = 5'd15;
    localparam logic [4:0] S_DVW  = 5'd16;
    localparam logic [4:0] S_M1   = 5'd17;
    localparam logic [4:0] S_M1W  = 5'd18;
    localparam logic [4:0] S_M2   = 5'd19;
    localparam logic [4:0] S_M2W  = 5'd20;
    localparam logic [4:0] S_MOD  = 5'd21;
    localparam logic [4:0] S_MODW = 5'd22;
    localparam logic [4:0] S_CHK  = 5'd23;
    localparam logic [4:0] S_WR   = 5'd24;

    logic [4:0] r_state, n_state;
    logic [1:0] r_q, n_q;
    logic [2:0] r_w, n_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_q     <= '0;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_w     <= n_w;
        end
    end

    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_w     = r_w;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.op)
                    OP_LOAD, OP_READ: begin
                        if (i_sts.rw_bad) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = ST_BAD_INDEX;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.p_rd  = 1'b1;
                            o_cmd.p_sel = P_RACA;
                            o_cmd.r_rd  = 1'b1;
                            o_cmd.r_sel = X_RA;
                            n_state     = (i_sts.op == OP_READ) ? S_RD1 : S_L1;
                        end
                    end
                    OP_SWAP: begin
                        if (i_sts.sw_bad) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = ST_BAD_INDEX;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.p_rd  = 1'b1;
                            o_cmd.p_sel = P_RACA;
                            n_state     = S_SA;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_res = RES_RD;
                n_state        = S_IDLE;
            end
            S_L1: n_state = S_L2;
            S_L2: begin
                o_cmd.r_we  = 1'b1;
                o_cmd.r_rd  = 1'b1;
                o_cmd.r_sel = X_CA;
                n_state     = S_L3;
            end
            S_L3: n_state = S_L4;
            S_L4: begin
                o_cmd.r_we   = !i_sts.diag;
                o_cmd.r_wsel = 1'b1;
                o_cmd.p_we   = 1'b1;
                o_cmd.p_sel  = P_RACA;
                n_state      = S_L5;
            end
            S_L5: begin
                o_cmd.p_we  = 1'b1;
                o_cmd.p_sel = P_CARA;
                o_cmd.emit  = 1'b1;
                n_state     = S_IDLE;
            end
            S_SA: begin
                o_cmd.p_rd  = 1'b1;
                o_cmd.p_sel = P_RBCB;
                n_state     = S_SB;
            end
            S_SB: begin
                o_cmd.p_rd  = 1'b1;
                o_cmd.p_sel = P_RACB;
                n_state     = S_SC;
            end
            S_SC: begin
                o_cmd.p_rd  = 1'b1;
                o_cmd.p_sel = P_RBCA;
                n_state     = S_SD;
            end
            S_SD: begin
                if (i_sts.light) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = ST_LIGHT;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.lim_init = 1'b1;
                    n_q            = X_RA;
                    n_state        = S_DVR;
                end
            end
            S_DVR: begin
                o_cmd.r_rd  = 1'b1;
                o_cmd.r_sel = r_q;
                n_state     = S_DVG;
            end
            S_DVG: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_q  = r_q;
                n_state      = S_DVW;
            end
            S_DVW: begin
                if (i_sts.div_done) begin
                    if (r_q == X_CB) begin
                        n_state = S_M1;
                    end else begin
                        n_q     = r_q + 2'd1;
                        n_state = S_DVR;
                    end
                end
            end
            S_M1: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_M1W;
            end
            S_M1W, S_M2W: begin
                if (i_sts.mul_done) begin
                    if (i_sts.cap_fail) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_st = ST_NO_CAP;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.lim_upd = 1'b1;
                        n_state       = (r_state == S_M1W) ? S_M2 : S_MOD;
                    end
                end
            end
            S_M2: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = 1'b1;
                n_state       = S_M2W;
            end
            S_MOD: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_mod = 1'b1;
                n_state       = S_MODW;
            end
            S_MODW: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.ovf) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_st = ST_NO_CAP;
                    n_state       = S_IDLE;
                end else begin
                    n_w     = '0;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.p_we  = 1'b1;
                o_cmd.p_sel = r_w;
                n_w         = r_w + 3'd1;
                if (r_w == P_CARB) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_res = RES_K;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("sequencer not idle after result");

    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |=> !i_sts.div_done)
        else $error("divider finished too early");

endmodule

// ===== hdl/degree_matrix_swap_engine.sv =====
// ----------------------------------------------------------------------------
// degree_matrix_swap_engine
// Symmetric joint degree count matrix with load, read and capacity-checked
// edge-pair swap attempts.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | dir
//  command   | start, i_opcode .. i_random_draw; busy out | in
//  result    | o_valid, o_status, o_result_value          | out
//
//  Reset runs a clearing pass over every pair entry and row total with busy
//  high. A swap attempt uses the bit-serial divider, RW (the row total width,
//  38 by default) bits wide and shared by four node counts and the step
//  modulo, and the serial multiplier.
//  o_valid lasts one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module degree_matrix_swap_engine #(
    parameter int DEGREE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_row_a,
    input  logic [5:0]  i_col_a,
    input  logic [5:0]  i_row_b,
    input  logic [5:0]  i_col_b,
    input  logic [31:0] i_count_value,
    input  logic [30:0] i_random_draw,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_value
);
    import dmse_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dmse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dmse_dpath #(.DEGREE_SLOTS(DEGREE_SLOTS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_opcode),
        .i_row_a        (i_row_a),
        .i_col_a        (i_col_a),
        .i_row_b        (i_row_b),
        .i_col_b        (i_col_b),
        .i_count_value  (i_count_value),
        .i_random_draw  (i_random_draw),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

endmodule

// ===== tb/sv/dmse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmse_checker
// Watches the command and result channels of the degree matrix swap engine,
// keeps its own copy of the pair count matrix and row totals, predicts the
// status and value of every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module dmse_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_row_a,
    input  logic [5:0]  i_col_a,
    input  logic [5:0]  i_row_b,
    input  logic [5:0]  i_col_b,
    input  logic [31:0] i_count_value,
    input  logic [30:0] i_random_draw,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [31:0] o_result_value,
    output int          o_fail_count,
    output int          o_pending
);
    import dmse_pkg::*;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } t_outcome;

    logic [31:0] pair_count [0:4095];
    logic [63:0] row_sum [0:63];
    t_outcome    outcome_q [$];

    function automatic logic [31:0] entry(int r, int c);
        return pair_count[r * 64 + c];
    endfunction

    // shrink the step limit to the free room of class (a,b); 0 when full
    function automatic bit room_left(int a, int b, inout logic [63:0] lim);
        logic [127:0] prod;
        logic [63:0]  cap;
        logic [63:0]  used;
        prod = 128'(row_sum[a] / 64'(a)) * 128'(row_sum[b] / 64'(b));
        cap  = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
        used = 64'(entry(a, b));
        if (cap <= used) return 0;
        if (cap - used < lim) lim = cap - used;
        return 1;
    endfunction

    function automatic t_outcome swap_outcome(int i1, int j1, int i2, int j2,
                                              logic [30:0] draw);
        t_outcome    res;
        logic [63:0] x1, x2, lim, k;
        res = '{ST_OK, 32'd0};
        if (i1 == 0 || j1 == 0 || i2 == 0 || j2 == 0 || i1 >= j1 || i2 >= j2 ||
            i2 == i1 || i2 == j1 || j2 == i1 || j2 == j1) begin
            res.status = ST_BAD_INDEX;
            return res;
        end
        x1 = 64'(entry(i1, j1));
        x2 = 64'(entry(i2, j2));
        if (x1 < 2 || x2 < 2) begin
            res.status = ST_LIGHT;
            return res;
        end
        lim = (x1 < x2) ? x1 : x2;
        if (!room_left(i1, j2, lim) || !room_left(i2, j1, lim)) begin
            res.status = ST_NO_CAP;
            return res;
        end
        k = 64'd1 + 64'(draw) % lim;
        if (64'(entry(i1, j2)) + k > 64'(COUNT_MAX) ||
            64'(entry(i2, j1)) + k > 64'(COUNT_MAX)) begin
            res.status = ST_NO_CAP;
            return res;
        end
        pair_count[i1 * 64 + j1] = 32'(x1 - k);
        pair_count[j1 * 64 + i1] = 32'(x1 - k);
        pair_count[i2 * 64 + j2] = 32'(x2 - k);
        pair_count[j2 * 64 + i2] = 32'(x2 - k);
        pair_count[i1 * 64 + j2] = entry(i1, j2) + 32'(k);
        pair_count[j2 * 64 + i1] = entry(i1, j2);
        pair_count[i2 * 64 + j1] = entry(i2, j1) + 32'(k);
        pair_count[j1 * 64 + i2] = entry(i2, j1);
        res.value = 32'(k);
        return res;
    endfunction

    function automatic t_outcome item_outcome(logic [1:0] op, int ra, int ca, int rb,
                                              int cb, logic [31:0] cnt,
                                              logic [30:0] draw);
        t_outcome    res;
        logic [63:0] old;
        res = '{ST_OK, 32'd0};
        case (op)
            OP_READ: res.value = entry(ra, ca);
            OP_LOAD: begin
                old = 64'(entry(ra, ca));
                row_sum[ra] = row_sum[ra] - old + 64'(cnt);
                if (ra != ca) row_sum[ca] = row_sum[ca] - old + 64'(cnt);
                pair_count[ra * 64 + ca] = cnt;
                pair_count[ca * 64 + ra] = cnt;
            end
            OP_SWAP: res = swap_outcome(ra, ca, rb, cb, draw);
            default: ;
        endcase
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        foreach (pair_count[n]) pair_count[n] = '0;
        foreach (row_sum[n]) row_sum[n] = '0;
    end

    assign o_pending = outcome_q.size();

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (start && !busy)
                outcome_q.push_back(item_outcome(i_opcode, i_row_a, i_col_a, i_row_b,
                                                 i_col_b, i_count_value, i_random_draw));
            if (o_valid) begin
                if (outcome_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result status %0d value %0d",
                                 $time, o_status, o_result_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== o_status || want.value !== o_result_value) begin
                        if (o_fail_count < 10)
                            $display("%0t: status exp %0d got %0d, value exp %0d got %0d",
                                     $time, want.status, o_status, want.value,
                                     o_result_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_degree_matrix_swap_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_degree_matrix_swap_engine
// Drives load, read and swap items into the degree matrix swap engine: a
// directed opening over the special cases, then random items built mostly as
// well-formed swaps on a populated matrix, with random gaps. The checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_degree_matrix_swap_engine;
    import dmse_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = OP_READ;
    logic [5:0]  i_row_a = '0;
    logic [5:0]  i_col_a = '0;
    logic [5:0]  i_row_b = '0;
    logic [5:0]  i_col_b = '0;
    logic [31:0] i_count_value = '0;
    logic [30:0] i_random_draw = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_result_value;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    degree_matrix_swap_engine dut (.*);

    dmse_checker u_checker (
        .o_fail_count(fail_count),
        .o_pending(pending),
        .*
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic issue(logic [1:0] op, int ra, int ca, int rb, int cb,
                         logic [31:0] cnt, logic [30:0] draw);
        start         <= 1'b1;
        i_opcode      <= op;
        i_row_a       <= 6'(ra);
        i_col_a       <= 6'(ca);
        i_row_b       <= 6'(rb);
        i_col_b       <= 6'(cb);
        i_count_value <= cnt;
        i_random_draw <= draw;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_item(int n);
        int          pick, span, a, b, c, d, t;
        logic [31:0] cnt;
        pick = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 63 : 8;
        cnt  = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(40);
        if (pick < 60) begin
            a = $urandom_range(span, 1);
            do b = $urandom_range(span, 1); while (b == a);
            do c = $urandom_range(span, 1); while (c == a || c == b);
            do d = $urandom_range(span, 1); while (d == a || d == b || d == c);
            if (a > b) begin t = a; a = b; b = t; end
            if (c > d) begin t = c; c = d; d = t; end
            issue(OP_SWAP, a, b, c, d, $urandom(), 31'($urandom()));
        end else if (pick < 78) begin
            issue(OP_LOAD, $urandom_range(span, 1), $urandom_range(span, 1), $urandom(),
                  $urandom(), cnt, 31'($urandom()));
        end else if (pick < 88) begin
            issue(OP_READ, $urandom_range(span), $urandom_range(span), $urandom(),
                  $urandom(), $urandom(), 31'($urandom()));
        end else begin
            issue(2'($urandom()), $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), $urandom_range(63), $urandom(), 31'($urandom()));
        end
        if (!(n >= 150 && n < 250) && $urandom_range(99) < 36)
            pause($urandom_range(6, 1));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_LOAD, 63, 63, 0, 0, 32'hFFFF_FFFF, '0);
        issue(OP_READ, 63, 63, 0, 0, '0, '0);
        issue(OP_LOAD, 0, 0, 0, 0, 32'd0, '0);
        issue(OP_READ, 0, 5, 0, 0, '0, '0);
        issue(OP_LOAD, 1, 2, 0, 0, 32'd10, '0);
        issue(OP_LOAD, 3, 4, 0, 0, 32'd10, '0);
        issue(OP_LOAD, 1, 3, 0, 0, 32'd1, '0);
        issue(OP_LOAD, 2, 4, 0, 0, 32'd1, '0);
        issue(OP_SWAP, 1, 2, 3, 4, '0, 31'h7FFF_FFFF);
        issue(OP_SWAP, 0, 2, 3, 4, '0, '0);
        issue(OP_SWAP, 2, 1, 3, 4, '0, '0);
        issue(OP_SWAP, 1, 2, 4, 3, '0, '0);
        issue(OP_SWAP, 1, 2, 2, 4, '0, '0);
        issue(OP_LOAD, 5, 6, 0, 0, 32'd1, '0);
        issue(OP_SWAP, 1, 2, 5, 6, '0, '0);
        issue(OP_LOAD, 7, 8, 0, 0, 32'd5, '0);
        issue(OP_SWAP, 1, 2, 7, 8, '0, '0);
        issue(OP_LOAD, 1, 9, 0, 0, 32'hFFFF_FFFF, '0);
        issue(OP_LOAD, 5, 9, 0, 0, 32'd10, '0);
        issue(OP_SWAP, 1, 2, 5, 9, '0, 31'd3);
        issue(2'd3, 63, 63, 63, 63, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        issue(OP_READ, 1, 9, 0, 0, '0, '0);
        drain();

        for (int n = 0; n < 430; n++) random_item(n);
        drain();
        repeat (2000) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dmse_pkg.sv
hdl/dmse_div.sv
hdl/dmse_mul.sv
hdl/dmse_dpath.sv
hdl/dmse_ctrl.sv
hdl/degree_matrix_swap_engine.sv
tb/sv/dmse_checker.sv
tb/sv/tb_degree_matrix_swap_engine.sv
